/* hdl/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int unsigned TOTAL_BLOCKS = 1024;
  localparam int unsigned RT_BLOCKS    = 64;
  localparam int unsigned MAX_IDS      = 256;

  // port field widths
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned PID_W  = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned SB_W   = 10;

  // internal widths
  localparam int unsigned BLK_W  = $clog2(TOTAL_BLOCKS);
  localparam int unsigned LEN_W  = $clog2(TOTAL_BLOCKS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_IDS);
  localparam int unsigned NID_W  = $clog2(MAX_IDS + 1);

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADID = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOIDS = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_ALLOC_ZERO,
    OP_FREE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             real_time;
    logic [CNT_W-1:0] need;
    logic [PID_W-1:0] pid;
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             busy;
  } seg_ent_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } bk_stat_t;

endpackage

/* hdl/ffba_front.sv */
// Front end: accepts requests, classifies them and queues them (two entries).
// Depends on ffba_pkg.
module ffba_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic                      real_time_i,
  input  logic [ffba_pkg::CNT_W-1:0] block_count_i,
  input  logic [ffba_pkg::PID_W-1:0] proc_id_i,
  output logic                      q_valid_o,
  output ffba_pkg::cmd_t            q_cmd_o,
  input  logic                      q_pop_i
);

  ffba_pkg::cmd_t fifo_q [2];
  ffba_pkg::cmd_t cmd;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  always_comb begin
    cmd.real_time = real_time_i;
    cmd.need      = block_count_i;
    cmd.pid       = proc_id_i;
    if (req_type_i) begin
      cmd.op = ffba_pkg::OP_FREE;
    end else if (block_count_i == '0) begin
      cmd.op = ffba_pkg::OP_ALLOC_ZERO;
    end else begin
      cmd.op = ffba_pkg::OP_ALLOC;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = fifo_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* hdl/ffba_back.sv */
// Back end: walks the segment chain in the segment memory, keeps the id table
// and drives the result register. Depends on ffba_pkg.
module ffba_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  ffba_pkg::cmd_t              q_cmd_i,
  output ffba_pkg::bk_stat_t          stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ffba_pkg::STAT_W-1:0] status_o,
  output logic [ffba_pkg::PID_W-1:0]  new_id_o,
  output logic [ffba_pkg::SB_W-1:0]   start_block_o
);

  localparam int unsigned BW = ffba_pkg::BLK_W;
  localparam int unsigned LW = ffba_pkg::LEN_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_WALK    = 3'd1;
  localparam logic [2:0] S_SPLIT   = 3'd2;
  localparam logic [2:0] S_FR_ID   = 3'd3;
  localparam logic [2:0] S_FR_SEG  = 3'd4;
  localparam logic [2:0] S_FR_NXT  = 3'd5;

  localparam logic [BW:0]   RT_END  = (BW+1)'(ffba_pkg::RT_BLOCKS);
  localparam logic [BW:0]   ALL_END = (BW+1)'(ffba_pkg::TOTAL_BLOCKS);

  // memories
  ffba_pkg::seg_ent_t seg_mem [ffba_pkg::TOTAL_BLOCKS];
  logic [BW-1:0]      id_mem  [ffba_pkg::MAX_IDS];

  ffba_pkg::seg_ent_t seg_rd_q, rd_ent, seg_wdata;
  logic [BW-1:0]      seg_raddr, rd_addr_q, seg_waddr;
  logic               seg_we;
  logic [BW-1:0]      id_rd_q;
  logic               id_we;
  logic [ffba_pkg::IDX_W-1:0] id_raddr, id_waddr;

  // blocks 0 and RT_BLOCKS hold their reset contents until first written
  logic [1:0]         init_q;

  logic [2:0]         state_q, state_d;
  ffba_pkg::cmd_t     cur_q, cur_d;
  logic [BW-1:0]      b_q, b_d;
  logic [BW:0]        end_q, end_d;
  logic [BW-1:0]      s_q, s_d;
  logic [LW-1:0]      len_q, len_d;
  logic [BW-1:0]      sp_addr_q, sp_addr_d;
  logic [LW-1:0]      sp_len_q, sp_len_d;
  logic [ffba_pkg::NID_W-1:0] next_id_q, next_id_d;
  logic [ffba_pkg::MAX_IDS-1:0] live_q, live_d;

  logic               ov_q, ov_d;
  logic [ffba_pkg::STAT_W-1:0] st_q, st_d;
  logic [ffba_pkg::PID_W-1:0]  nid_q, nid_d;
  logic [ffba_pkg::SB_W-1:0]   sb_q, sb_d;
  logic               res_set;

  logic               pop;
  logic               ids_out, fits;
  logic [BW:0]        nxt_b, nb_free, s_end;
  logic [ffba_pkg::IDX_W-1:0] pid_idx;
  logic               pid_ok;

  always_comb begin
    rd_ent = seg_rd_q;
    if (rd_addr_q == '0 && !init_q[0]) begin
      rd_ent.len  = LW'(ffba_pkg::RT_BLOCKS);
      rd_ent.busy = 1'b0;
    end else if (rd_addr_q == BW'(ffba_pkg::RT_BLOCKS) && !init_q[1]) begin
      rd_ent.len  = LW'(ffba_pkg::TOTAL_BLOCKS - ffba_pkg::RT_BLOCKS);
      rd_ent.busy = 1'b0;
    end
  end

  assign ids_out = (32'(next_id_q) >= ffba_pkg::MAX_IDS);
  assign fits    = !rd_ent.busy && (32'(rd_ent.len) >= 32'(cur_q.need));
  assign nxt_b   = (BW+1)'(b_q) + (BW+1)'(rd_ent.len);
  assign nb_free = (BW+1)'(s_q) + (BW+1)'(rd_ent.len);
  assign s_end   = (32'(s_q) < ffba_pkg::RT_BLOCKS) ? RT_END : ALL_END;
  assign pid_idx = ffba_pkg::IDX_W'(q_cmd_i.pid);
  assign pid_ok  = (32'(q_cmd_i.pid) < ffba_pkg::MAX_IDS) && live_q[pid_idx];
  assign pop     = (state_q == S_IDLE) && q_valid_i && (!ov_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    b_d       = b_q;
    end_d     = end_q;
    s_d       = s_q;
    len_d     = len_q;
    sp_addr_d = sp_addr_q;
    sp_len_d  = sp_len_q;
    next_id_d = next_id_q;
    live_d    = live_q;
    res_set   = 1'b0;
    st_d      = ffba_pkg::STAT_OK;
    nid_d     = '0;
    sb_d      = '0;
    seg_raddr = b_q;
    seg_we    = 1'b0;
    seg_waddr = b_q;
    seg_wdata = '0;
    id_we     = 1'b0;
    id_waddr  = ffba_pkg::IDX_W'(next_id_q);
    id_raddr  = pid_idx;

    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          cur_d = q_cmd_i;
          unique case (q_cmd_i.op)
            ffba_pkg::OP_FREE: begin
              if (pid_ok) begin
                live_d[pid_idx] = 1'b0;
                state_d = S_FR_ID;
              end else begin
                res_set = 1'b1;
                st_d    = ffba_pkg::STAT_BADID;
              end
            end
            ffba_pkg::OP_ALLOC_ZERO: begin
              res_set = 1'b1;
              st_d    = ids_out ? ffba_pkg::STAT_NOIDS : ffba_pkg::STAT_NOFIT;
            end
            ffba_pkg::OP_ALLOC: begin
              if (ids_out) begin
                res_set = 1'b1;
                st_d    = ffba_pkg::STAT_NOIDS;
              end else begin
                b_d       = q_cmd_i.real_time ? '0 : BW'(ffba_pkg::RT_BLOCKS);
                end_d     = q_cmd_i.real_time ? RT_END : ALL_END;
                seg_raddr = b_d;
                state_d   = S_WALK;
              end
            end
            default: begin
              res_set = 1'b1;
              st_d    = ffba_pkg::STAT_NOFIT;
            end
          endcase
        end
      end
      S_WALK: begin
        if (fits) begin
          seg_we         = 1'b1;
          seg_waddr      = b_q;
          seg_wdata.len  = LW'(cur_q.need);
          seg_wdata.busy = 1'b1;
          id_we          = 1'b1;
          live_d[ffba_pkg::IDX_W'(next_id_q)] = 1'b1;
          next_id_d      = next_id_q + 1'b1;
          res_set        = 1'b1;
          nid_d          = ffba_pkg::PID_W'(next_id_q);
          sb_d           = ffba_pkg::SB_W'(b_q);
          if (32'(rd_ent.len) > 32'(cur_q.need)) begin
            // leftover becomes a new free segment
            sp_addr_d = b_q + BW'(cur_q.need);
            sp_len_d  = rd_ent.len - LW'(cur_q.need);
            state_d   = S_SPLIT;
          end else begin
            state_d = S_IDLE;
          end
        end else if (nxt_b >= end_q) begin
          res_set = 1'b1;
          st_d    = ffba_pkg::STAT_NOFIT;
          state_d = S_IDLE;
        end else begin
          b_d       = nxt_b[BW-1:0];
          seg_raddr = nxt_b[BW-1:0];
        end
      end
      S_SPLIT: begin
        seg_we         = 1'b1;
        seg_waddr      = sp_addr_q;
        seg_wdata.len  = sp_len_q;
        seg_wdata.busy = 1'b0;
        state_d        = S_IDLE;
      end
      S_FR_ID: begin
        s_d       = id_rd_q;
        seg_raddr = id_rd_q;
        state_d   = S_FR_SEG;
      end
      S_FR_SEG: begin
        len_d = rd_ent.len;
        if (nb_free < s_end) begin
          seg_raddr = nb_free[BW-1:0];
          state_d   = S_FR_NXT;
        end else begin
          seg_we         = 1'b1;
          seg_waddr      = s_q;
          seg_wdata.len  = rd_ent.len;
          seg_wdata.busy = 1'b0;
          res_set        = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FR_NXT: begin
        // merge with the following segment only when it is free
        seg_we         = 1'b1;
        seg_waddr      = s_q;
        seg_wdata.busy = 1'b0;
        seg_wdata.len  = rd_ent.busy ? len_q : len_q + rd_ent.len;
        res_set        = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
    seg_rd_q  <= seg_mem[seg_raddr];
    rd_addr_q <= seg_raddr;
    if (id_we) begin
      id_mem[id_waddr] <= b_q;
    end
    id_rd_q <= id_mem[id_raddr];
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    b_q       <= b_d;
    end_q     <= end_d;
    s_q       <= s_d;
    len_q     <= len_d;
    sp_addr_q <= sp_addr_d;
    sp_len_q  <= sp_len_d;
    if (res_set) begin
      st_q  <= st_d;
      nid_q <= nid_d;
      sb_q  <= sb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      next_id_q <= '0;
      live_q    <= '0;
      init_q    <= 2'b00;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      live_q    <= live_d;
      if (seg_we && seg_waddr == '0) init_q[0] <= 1'b1;
      if (seg_we && seg_waddr == BW'(ffba_pkg::RT_BLOCKS)) init_q[1] <= 1'b1;
      if (res_set) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign stat_o.pop     = pop;
  assign stat_o.busy    = (state_q != S_IDLE);
  assign out_valid_o    = ov_q;
  assign status_o       = st_q;
  assign new_id_o       = nid_q;
  assign start_block_o  = sb_q;

endmodule

/* hdl/first_fit_block_allocator_top.sv */
// First-fit block allocator, top level. Depends on ffba_pkg, ffba_front, ffba_back.
// Immediate rejects are answered straight from idle; an allocate walks the chain one segment
// read per cycle, then writes the taken segment and, for a split, the leftover; a free reads
// the id table, then the segment, then the next segment when it lies in the same region, and
// writes the freed segment. One item at a time: a new one only when idle and the result is free.
// Reset: asynchronous, active low; clears ids, id valid bits and control state.
module first_fit_block_allocator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic                        real_time_i,
  input  logic [ffba_pkg::CNT_W-1:0]  block_count_i,
  input  logic [ffba_pkg::PID_W-1:0]  proc_id_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ffba_pkg::STAT_W-1:0] status_o,
  output logic [ffba_pkg::PID_W-1:0]  new_id_o,
  output logic [ffba_pkg::SB_W-1:0]   start_block_o
);

  logic               q_valid;
  ffba_pkg::cmd_t     q_cmd;
  ffba_pkg::bk_stat_t bk_stat;

  ffba_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .req_type_i,
    .real_time_i,
    .block_count_i,
    .proc_id_i,
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (bk_stat.pop)
  );

  ffba_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .stat_o    (bk_stat),
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .new_id_o,
    .start_block_o
  );

`ifndef SYNTHESIS
  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> !bk_stat.busy && q_valid)
    else $error("back end took an item while busy");
  a_pop_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> (!out_valid_o || out_ready_i))
    else $error("item taken while result register is occupied");
  a_push_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> q_valid)
    else $error("accepted item missing from queue");
`endif

endmodule

/* dv/tb_first_fit_block_allocator_top.sv */
// Testbench for the first-fit block allocator: directed and random requests,
// checked against a behavioral allocator model in a small scoreboard class.
// Depends on ffba_pkg and first_fit_block_allocator_top.
module tb_first_fit_block_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_RAND  = 1030;
  localparam int unsigned WDOG_MAX  = 20000;
  localparam int unsigned BIG_STALL = 60;

  typedef struct packed {
    logic [ffba_pkg::STAT_W-1:0] status;
    logic [ffba_pkg::PID_W-1:0]  new_id;
    logic [ffba_pkg::SB_W-1:0]   start_block;
  } alloc_rsp_t;

  class alloc_scoreboard;
    bit [ffba_pkg::LEN_W-1:0] seg_len[ffba_pkg::TOTAL_BLOCKS];
    bit                       seg_head[ffba_pkg::TOTAL_BLOCKS];
    bit                       seg_used[ffba_pkg::TOTAL_BLOCKS];
    bit [ffba_pkg::BLK_W-1:0] id_base[ffba_pkg::MAX_IDS];
    bit                       id_valid[ffba_pkg::MAX_IDS];
    int unsigned              id_next;
    alloc_rsp_t               pending[$];
    int unsigned              n_bad;
    int unsigned              n_checked;
    int unsigned              n_alloc_ok;
    int unsigned              n_free_ok;

    function new();
      foreach (seg_len[i]) begin
        seg_len[i] = '0;
        seg_head[i] = 1'b0;
        seg_used[i] = 1'b0;
      end
      foreach (id_valid[i]) begin
        id_valid[i] = 1'b0;
        id_base[i] = '0;
      end
      seg_head[0] = 1'b1;
      seg_len[0] = ffba_pkg::LEN_W'(ffba_pkg::RT_BLOCKS);
      seg_head[ffba_pkg::RT_BLOCKS] = 1'b1;
      seg_len[ffba_pkg::RT_BLOCKS] =
        ffba_pkg::LEN_W'(ffba_pkg::TOTAL_BLOCKS - ffba_pkg::RT_BLOCKS);
      id_next = 0;
      n_bad = 0;
      n_checked = 0;
      n_alloc_ok = 0;
      n_free_ok = 0;
    endfunction

    function void note_request(bit is_free, bit rt, bit [ffba_pkg::CNT_W-1:0] cnt,
                               bit [ffba_pkg::PID_W-1:0] pid);
      alloc_rsp_t  r;
      int unsigned b, lim, len, s, nb, rend;
      bit          done;
      r = '0;
      done = 1'b0;
      if (!is_free) begin
        b = rt ? 0 : ffba_pkg::RT_BLOCKS;
        lim = rt ? ffba_pkg::RT_BLOCKS : ffba_pkg::TOTAL_BLOCKS;
        if (id_next >= ffba_pkg::MAX_IDS) r.status = ffba_pkg::STAT_NOIDS;
        else if (cnt == 0) r.status = ffba_pkg::STAT_NOFIT;
        else begin
          r.status = ffba_pkg::STAT_NOFIT;
          while (b < lim && !done) begin
            len = seg_len[b];
            if (len == 0) break;
            if (!seg_used[b] && len >= cnt) begin
              seg_used[b] = 1'b1;
              if (len > cnt) begin
                seg_len[b] = cnt;
                seg_head[b + cnt] = 1'b1;
                seg_len[b + cnt] = ffba_pkg::LEN_W'(len - cnt);
                seg_used[b + cnt] = 1'b0;
              end
              id_base[id_next] = ffba_pkg::BLK_W'(b);
              id_valid[id_next] = 1'b1;
              r.status = ffba_pkg::STAT_OK;
              r.new_id = ffba_pkg::PID_W'(id_next);
              r.start_block = ffba_pkg::SB_W'(b);
              id_next++;
              n_alloc_ok++;
              done = 1'b1;
            end else b += len;
          end
        end
      end else if (!id_valid[pid]) r.status = ffba_pkg::STAT_BADID;
      else begin
        id_valid[pid] = 1'b0;
        s = id_base[pid];
        seg_used[s] = 1'b0;
        nb = s + seg_len[s];
        rend = (s < ffba_pkg::RT_BLOCKS) ? ffba_pkg::RT_BLOCKS : ffba_pkg::TOTAL_BLOCKS;
        // merge forward only, never across the region border
        if (nb < rend && seg_head[nb] && !seg_used[nb]) begin
          seg_len[s] = seg_len[s] + seg_len[nb];
          seg_head[nb] = 1'b0;
          seg_len[nb] = '0;
        end
        r.status = ffba_pkg::STAT_OK;
        n_free_ok++;
      end
      pending.push_back(r);
    endfunction

    function void check_result(alloc_rsp_t got);
      alloc_rsp_t exp_r;
      n_checked++;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result: %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: exp st=%0d id=%0d sb=%0d got st=%0d id=%0d sb=%0d",
                   exp_r.status, exp_r.new_id, exp_r.start_block,
                   got.status, got.new_id, got.start_block);
      end
    endfunction
  endclass

  logic                        clk_i, rst_ni;
  logic                        in_valid_i, in_ready_o;
  logic                        req_type_i, real_time_i;
  logic [ffba_pkg::CNT_W-1:0]  block_count_i;
  logic [ffba_pkg::PID_W-1:0]  proc_id_i;
  logic                        out_valid_o, out_ready_i;
  logic [ffba_pkg::STAT_W-1:0] status_o;
  logic [ffba_pkg::PID_W-1:0]  new_id_o;
  logic [ffba_pkg::SB_W-1:0]   start_block_o;

  first_fit_block_allocator_top dut (.*);

  alloc_scoreboard sb;
  bit              hold_off;
  int unsigned     idle_cycles;
  int unsigned     n_sent;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_req(bit is_free, bit rt, bit [ffba_pkg::CNT_W-1:0] cnt,
                          bit [ffba_pkg::PID_W-1:0] pid);
    int unsigned gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= is_free;
    real_time_i <= rt;
    block_count_i <= cnt;
    proc_id_i <= pid;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(is_free, rt, cnt, pid);
    n_sent++;
  endtask

  task automatic send_alloc(bit rt, bit [ffba_pkg::CNT_W-1:0] cnt);
    send_req(1'b0, rt, cnt, ffba_pkg::PID_W'($urandom_range(0, 255)));
  endtask

  task automatic send_free(bit [ffba_pkg::PID_W-1:0] pid);
    send_req(1'b1, 1'($urandom_range(0, 1)), ffba_pkg::CNT_W'($urandom_range(0, 2047)),
             pid);
  endtask

  // receiver: random stalls per item, plus one long hold-off on request
  initial begin
    int unsigned wait_n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (BIG_STALL) @(posedge clk_i);
        hold_off = 1'b0;
      end
      wait_n = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 4);
      if (wait_n != 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result('{status_o, new_id_o, start_block_o});
    end
  end

  // watchdog on cycles with no accepted item
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned k, r;
    sb = new();
    hold_off = 1'b0;
    n_sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = 1'b0;
    real_time_i = 1'b0;
    block_count_i = '0;
    proc_id_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero length, oversize, exact fits, unknown id, double free
    send_alloc(1'b1, 11'd0);
    send_alloc(1'b1, 11'd65);
    send_alloc(1'b0, 11'd2047);
    send_alloc(1'b0, 11'd961);
    send_alloc(1'b1, 11'd1);
    send_alloc(1'b1, 11'd63);
    send_alloc(1'b1, 11'd1);
    send_alloc(1'b0, 11'd960);
    send_free(8'd255);
    send_free(8'd0);
    send_free(8'd0);
    send_free(8'd1);
    send_alloc(1'b1, 11'd64);
    send_free(8'd2);
    send_alloc(1'b0, 11'd1024);
    send_alloc(1'b0, 11'd1);
    send_free(8'd4);
    send_free(8'd5);
    send_alloc(1'b1, 11'd1);
    send_alloc(1'b0, 11'd1);

    // back up output while input keeps coming
    hold_off = 1'b1;
    for (k = 0; k < 12; k++) send_alloc(k[0], ffba_pkg::CNT_W'($urandom_range(1, 8)));

    for (k = 0; k < NUM_RAND; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        // mostly small sizes, a few large
        if ($urandom_range(0, 9) == 0)
          send_alloc(1'($urandom_range(0, 1)), ffba_pkg::CNT_W'($urandom_range(0, 2047)));
        else send_alloc(1'($urandom_range(0, 1)), ffba_pkg::CNT_W'($urandom_range(1, 40)));
      end else if (r < 85 && sb.id_next > 0)
        send_free(ffba_pkg::PID_W'($urandom_range(0, sb.id_next - 1)));
      else send_free(ffba_pkg::PID_W'($urandom_range(0, 255)));
    end
    in_valid_i <= 1'b0;

    k = 0;
    while (sb.pending.size() != 0 && k < 20000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (100) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results: %0d allocations, %0d frees ok",
             n_sent, sb.n_checked, sb.n_alloc_ok, sb.n_free_ok);
    $display("ids issued %0d, mismatches %0d", sb.id_next, sb.n_bad);
    if (sb.n_bad == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
